>>> sv/stb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

    localparam int REQ_W   = 3;
    localparam int IDX_W   = 4;
    localparam int TIME_W  = 64;
    // Only indexes that fit in the timer index field can ever be addressed.
    localparam int MAX_SLOTS = 16;

    localparam logic [REQ_W-1:0] REQ_CONFIG = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_STOP   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RESET  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the incoming beat, clear scan and pending report
        logic rd_scan;    // read the stores at the scan pointer
        logic rd_next;    // read the stores at the scan pointer plus one
        logic apply_req;  // execute a single-timer request and emit its result
        logic eval;       // evaluate the timer at the scan pointer and advance
        logic finish;     // emit the closing result of a tick
    } stb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_tick;    // the beat offered on the input is a tick
        logic hit;        // timer at the scan pointer is active and expired
        logic pend_valid; // a report is held back, waiting to learn if it is the final one
        logic scan_last;  // the scan pointer is at the highest timer
        logic out_free;   // the output register can take a result this cycle
    } stb_stat_t;

endpackage

`default_nettype wire

>>> sv/stb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module stb_ctrl
    import stb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire stb_stat_t stat,
    output stb_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_REQ_RD   = 3'd1;
    localparam logic [2:0] ST_REQ_EX   = 3'd2;
    localparam logic [2:0] ST_TICK_RD  = 3'd3;
    localparam logic [2:0] ST_TICK_EV  = 3'd4;
    localparam logic [2:0] ST_TICK_FIN = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_tick ? ST_TICK_RD : ST_REQ_RD;
                end
            end
            ST_REQ_RD:
            begin
                state_next = ST_REQ_EX;
            end
            ST_REQ_EX:
            begin
                if (stat.out_free)
                begin
                    cmd.apply_req = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_TICK_RD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = ST_TICK_EV;
            end
            ST_TICK_EV:
            begin
                // A new hit pushes the held report out, so it needs room downstream.
                if (stat.hit && stat.pend_valid && !stat.out_free)
                begin
                    cmd.rd_scan = 1'b1;
                end
                else
                begin
                    cmd.eval = 1'b1;
                    if (stat.scan_last)
                    begin
                        cmd.rd_scan = 1'b1;
                        state_next  = ST_TICK_FIN;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            ST_TICK_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/stb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module stb_datapath
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire stb_cmd_t          cmd,
    output stb_stat_t              stat,
    input  wire logic [REQ_W-1:0]  in_req_type,
    input  wire logic [IDX_W-1:0]  in_timer_index,
    input  wire logic [TIME_W-1:0] in_now_ns,
    input  wire logic [TIME_W-1:0] in_period,
    input  wire logic              in_reload_mode,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_status,
    output logic                   out_expired_valid,
    output logic [IDX_W-1:0]       out_expired_index,
    output logic                   out_last
);

    localparam int NUM_SLOTS = (NUM_TIMERS < MAX_SLOTS) ? NUM_TIMERS : MAX_SLOTS;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Captured request.
    logic [REQ_W-1:0]  req_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] period_reg;
    logic              reload_in_reg;

    // Per-timer flags.
    logic [NUM_SLOTS-1:0] active_reg, active_next;
    logic [NUM_SLOTS-1:0] reload_reg, reload_next;
    logic [NUM_SLOTS-1:0] pvalid_reg, pvalid_next;

    // Period and expiry stores with registered reads.
    logic [TIME_W-1:0] period_mem [NUM_SLOTS];
    logic [TIME_W-1:0] expiry_mem [NUM_SLOTS];
    logic [TIME_W-1:0] per_q;
    logic [TIME_W-1:0] exp_q;
    logic              pvalid_q;

    logic [SLOT_W-1:0] scan_reg;
    logic              pend_valid_reg;
    logic [SLOT_W-1:0] pend_idx_reg;

    logic              out_valid_reg;
    logic              out_status_reg;
    logic              out_exp_valid_reg;
    logic [IDX_W-1:0]  out_exp_index_reg;
    logic              out_last_reg;

    logic [SLOT_W-1:0] idx_s;
    logic              idx_ok;
    logic [SLOT_W-1:0] rd_addr;
    logic [TIME_W-1:0] period_eff;
    logic [TIME_W-1:0] sum;
    logic              hit;
    logic              bad;
    logic              per_we;
    logic              exp_we;
    logic [SLOT_W-1:0] exp_waddr;
    logic              out_free;

    assign idx_s  = idx_reg[SLOT_W-1:0];
    assign idx_ok = ({1'b0, idx_reg} < (IDX_W + 1)'(NUM_SLOTS));

    always_comb
    begin
        if (cmd.rd_next)
        begin
            rd_addr = SLOT_W'(scan_reg + 1'b1);
        end
        else if (cmd.rd_scan)
        begin
            rd_addr = scan_reg;
        end
        else
        begin
            rd_addr = idx_s;
        end
    end

    // A period never written since reset or delete reads as zero.
    assign period_eff = pvalid_q ? per_q : '0;
    assign sum        = now_reg + period_eff;
    assign hit        = active_reg[scan_reg] && (now_reg >= exp_q);
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        bad = !idx_ok;
        unique case (req_reg)
            REQ_CONFIG: bad = bad || (period_reg == '0);
            REQ_START,
            REQ_STOP,
            REQ_DELETE: bad = bad;
            REQ_RESET:  bad = bad || !active_reg[idx_s];
            default:    bad = 1'b1;
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        reload_next = reload_reg;
        pvalid_next = pvalid_reg;
        per_we      = 1'b0;
        exp_we      = 1'b0;
        exp_waddr   = idx_s;
        if (cmd.apply_req && !bad)
        begin
            unique case (req_reg)
                REQ_CONFIG:
                begin
                    per_we             = 1'b1;
                    pvalid_next[idx_s] = 1'b1;
                    reload_next[idx_s] = reload_in_reg;
                    active_next[idx_s] = 1'b0;
                end
                REQ_START:
                begin
                    exp_we             = 1'b1;
                    active_next[idx_s] = 1'b1;
                end
                REQ_STOP:
                begin
                    active_next[idx_s] = 1'b0;
                end
                REQ_DELETE:
                begin
                    pvalid_next[idx_s] = 1'b0;
                    reload_next[idx_s] = 1'b0;
                    active_next[idx_s] = 1'b0;
                end
                REQ_RESET:
                begin
                    exp_we = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.eval && hit)
        begin
            exp_waddr = scan_reg;
            if (reload_reg[scan_reg])
            begin
                exp_we = 1'b1;
            end
            else
            begin
                active_next[scan_reg] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        per_q    <= period_mem[rd_addr];
        exp_q    <= expiry_mem[rd_addr];
        pvalid_q <= pvalid_reg[rd_addr];
        if (per_we)
        begin
            period_mem[idx_s] <= period_reg;
        end
        if (exp_we)
        begin
            expiry_mem[exp_waddr] <= sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg       <= in_req_type;
            idx_reg       <= in_timer_index;
            now_reg       <= in_now_ns;
            period_reg    <= in_period;
            reload_in_reg <= in_reload_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            reload_reg     <= '0;
            pvalid_reg     <= '0;
            scan_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            reload_reg <= reload_next;
            pvalid_reg <= pvalid_next;
            if (cmd.load)
            begin
                scan_reg       <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.eval)
            begin
                scan_reg <= SLOT_W'(scan_reg + 1'b1);
                if (hit)
                begin
                    pend_valid_reg <= 1'b1;
                    pend_idx_reg   <= scan_reg;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.apply_req || cmd.finish || (cmd.eval && hit && pend_valid_reg))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply_req)
        begin
            out_status_reg    <= bad;
            out_exp_valid_reg <= 1'b0;
            out_exp_index_reg <= '0;
            out_last_reg      <= 1'b1;
        end
        else if (cmd.finish)
        begin
            out_status_reg    <= 1'b0;
            out_exp_valid_reg <= pend_valid_reg;
            out_exp_index_reg <= pend_valid_reg ? IDX_W'(pend_idx_reg) : '0;
            out_last_reg      <= 1'b1;
        end
        else if (cmd.eval && hit && pend_valid_reg)
        begin
            out_status_reg    <= 1'b0;
            out_exp_valid_reg <= 1'b1;
            out_exp_index_reg <= IDX_W'(pend_idx_reg);
            out_last_reg      <= 1'b0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_status        = out_status_reg;
    assign out_expired_valid = out_exp_valid_reg;
    assign out_expired_index = out_exp_index_reg;
    assign out_last          = out_last_reg;

    assign stat.in_tick    = (in_req_type == REQ_TICK);
    assign stat.hit        = hit;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.scan_last  = (scan_reg == SLOT_W'(NUM_SLOTS - 1));
    assign stat.out_free   = out_free;

endmodule

`default_nettype wire

>>> sv/software_timer_bank_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Bank of software timers, each with a period, a one-shot or auto-reload mode, an
// active flag and an expiry time in nanoseconds. One request beat addresses one
// timer to configure, start, stop, delete or reset it and returns exactly one result
// beat, or it is a tick carrying the current time, which returns one beat for every
// active timer whose expiry is at or before that time, in ascending index order,
// with tlast on the final beat; a tick with no expiry returns a single beat with
// expired_valid low. Auto-reload timers are rearmed at now plus their period and
// one-shot timers go inactive. All time sums wrap modulo 2^64. Only timers below
// both NUM_TIMERS and 16 can be addressed; other indexes report an invalid status.
// Flow: a single-timer request passes through a read state and an execute state, which
// places its result in the output register once that register is free.
// A tick reads the first timer, then scans the timers in ascending order through the
// read port of the expiry and period stores, one timer per cycle unless a hit must push
// out a held report while the output register is full, then places its closing result.
// Back-pressure on the result side stalls both. The next request is accepted as soon
// as the previous one has placed its last result in the output register.

module software_timer_bank_top
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [3:0] timer_index, [67:4] now_ns, [131:68] period, [132] reload_mode,
    // [135:133] zero
    input  wire logic [135:0] s_axis_tdata,
    // [2:0] req_type
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [0] status, [1] expired_valid, [5:2] expired_index, [7:6] zero
    output logic [7:0]        m_axis_tdata,
    output logic              m_axis_tlast
);

    stb_cmd_t         cmd;
    stb_stat_t        stat;
    logic             status;
    logic             expired_valid;
    logic [IDX_W-1:0] expired_index;

    stb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stb_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .in_req_type       (s_axis_tuser),
        .in_timer_index    (s_axis_tdata[3:0]),
        .in_now_ns         (s_axis_tdata[67:4]),
        .in_period         (s_axis_tdata[131:68]),
        .in_reload_mode    (s_axis_tdata[132]),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_status        (status),
        .out_expired_valid (expired_valid),
        .out_expired_index (expired_index),
        .out_last          (m_axis_tlast)
    );

    // The pad bits of the request beat carry no meaning and are not used.
    assign m_axis_tdata = {2'b00, expired_index, expired_valid, status};

endmodule

`default_nettype wire

>>> test/tb_software_timer_bank_top.sv
`timescale 1ns / 1ps

module tb_software_timer_bank_top;
    import stb_pkg::*;

    localparam int NUM_TIMERS     = 16;
    localparam int STALL_PCT      = 23;
    // Cycles with no beat accepted on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Settling time after the last drain, with a margin over a full-bank tick.
    localparam int SETTLE_CYCLES  = 2 * (NUM_TIMERS + 3);

    localparam logic [REQ_W-1:0]  REQ_BAD_6  = 3'd6;
    localparam logic [REQ_W-1:0]  REQ_BAD_7  = 3'd7;
    localparam logic              ST_OK      = 1'b0;
    localparam logic              ST_INVALID = 1'b1;
    localparam logic [TIME_W-1:0] TIME_MAX   = '1;

    typedef struct packed {
        logic             status;
        logic             exp_valid;
        logic [IDX_W-1:0] exp_index;
        logic             last;
    } timer_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;
    logic         m_axis_tlast;

    // Shadow copy of the timer bank, updated as each request beat is accepted.
    logic [TIME_W-1:0] shadow_period [NUM_TIMERS];
    logic [TIME_W-1:0] shadow_expiry [NUM_TIMERS];
    bit                shadow_active [NUM_TIMERS];
    bit                shadow_reload [NUM_TIMERS];

    timer_result_t     pending_results [$];
    int                err_count;
    int                quiet_cycles;
    bit                src_stall_en;
    bit                snk_stall_en;
    logic [TIME_W-1:0] sim_now;

    software_timer_bank_top #(
        .NUM_TIMERS(NUM_TIMERS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void push_single(logic st);
        timer_result_t r;
        r.status    = st;
        r.exp_valid = 1'b0;
        r.exp_index = '0;
        r.last      = 1'b1;
        pending_results.push_back(r);
    endfunction

    // Applies one request to the shadow bank and queues the beats it should produce.
    function automatic void predict_timer_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                                                  logic [TIME_W-1:0] now,
                                                  logic [TIME_W-1:0] period, logic reload);
        bit            hit [NUM_TIMERS];
        int            top_hit;
        timer_result_t r;
        logic          st;
        top_hit = -1;
        st      = ST_OK;
        if (req == REQ_TICK)
        begin
            // Decide all hits first so the final report can carry tlast.
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                hit[i] = shadow_active[i] && (now >= shadow_expiry[i]);
                if (hit[i])
                    top_hit = i;
            end
            if (top_hit < 0)
                push_single(ST_OK);
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                if (hit[i])
                begin
                    r.status    = ST_OK;
                    r.exp_valid = 1'b1;
                    r.exp_index = i[IDX_W-1:0];
                    r.last      = (i == top_hit);
                    pending_results.push_back(r);
                    if (shadow_reload[i])
                        shadow_expiry[i] = now + shadow_period[i];
                    else
                        shadow_active[i] = 1'b0;
                end
            end
            return;
        end
        if (int'(idx) >= NUM_TIMERS)
        begin
            push_single(ST_INVALID);
            return;
        end
        case (req)
            REQ_CONFIG:
            begin
                if (period == '0)
                    st = ST_INVALID;
                else
                begin
                    shadow_period[idx] = period;
                    shadow_expiry[idx] = '0;
                    shadow_reload[idx] = reload;
                    shadow_active[idx] = 1'b0;
                end
            end
            REQ_START:
            begin
                shadow_expiry[idx] = now + shadow_period[idx];
                shadow_active[idx] = 1'b1;
            end
            REQ_STOP:
                shadow_active[idx] = 1'b0;
            REQ_DELETE:
            begin
                shadow_period[idx] = '0;
                shadow_expiry[idx] = '0;
                shadow_reload[idx] = 1'b0;
                shadow_active[idx] = 1'b0;
            end
            REQ_RESET:
            begin
                if (!shadow_active[idx])
                    st = ST_INVALID;
                else
                    shadow_expiry[idx] = now + shadow_period[idx];
            end
            default:
                st = ST_INVALID;
        endcase
        push_single(st);
    endfunction

    // Drives one request beat from a falling edge and returns once it has been accepted.
    // Valid is left high so back-to-back beats never lower and raise it in one step.
    task automatic send_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                                logic [TIME_W-1:0] now, logic [TIME_W-1:0] period,
                                logic reload);
        @(negedge clk);
        while (src_stall_en && ($urandom_range(99) < STALL_PCT))
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {3'b000, reload, period, now, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_timer_request(req, idx, now, period, reload);
    endtask

    // Holds the sender off until every queued result has been seen.
    task automatic wait_for_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_rejects();
        send_request(REQ_TICK, 4'd0, '0, '0, 1'b0);
        send_request(REQ_CONFIG, 4'd2, '0, '0, 1'b1);
        send_request(REQ_RESET, 4'd3, '0, '0, 1'b0);
        send_request(REQ_BAD_6, 4'd0, TIME_MAX, TIME_MAX, 1'b1);
        send_request(REQ_BAD_7, 4'd15, TIME_MAX, TIME_MAX, 1'b1);
    endtask

    task automatic test_wrap_and_extremes();
        send_request(REQ_CONFIG, 4'd0, '0, 64'd1, 1'b0);
        send_request(REQ_CONFIG, 4'd15, '0, TIME_MAX, 1'b1);
        send_request(REQ_START, 4'd0, '0, '0, 1'b0);
        // The expiry of timer 15 wraps around to 4.
        send_request(REQ_START, 4'd15, 64'd5, '0, 1'b0);
        send_request(REQ_TICK, 4'd0, '0, '0, 1'b0);
        send_request(REQ_TICK, 4'd0, TIME_MAX, '0, 1'b0);
        send_request(REQ_RESET, 4'd15, '0, '0, 1'b0);
        send_request(REQ_STOP, 4'd15, '0, '0, 1'b0);
        send_request(REQ_STOP, 4'd15, '0, '0, 1'b0);
        send_request(REQ_RESET, 4'd15, '0, '0, 1'b0);
    endtask

    task automatic test_expiry_at_now();
        // Timer 7 still has a zero period, so it expires exactly at its start time.
        send_request(REQ_START, 4'd7, 64'd100, '0, 1'b0);
        send_request(REQ_TICK, 4'd0, 64'd99, '0, 1'b0);
        send_request(REQ_TICK, 4'd0, 64'd100, '0, 1'b0);
        // Restarting an active timer must not report it twice.
        send_request(REQ_START, 4'd7, 64'd200, '0, 1'b0);
        send_request(REQ_START, 4'd7, 64'd200, '0, 1'b0);
        send_request(REQ_TICK, 4'd0, 64'd200, '0, 1'b0);
    endtask

    task automatic test_delete_restart();
        send_request(REQ_DELETE, 4'd0, '0, '0, 1'b0);
        send_request(REQ_START, 4'd0, 64'd50, '0, 1'b0);
        send_request(REQ_TICK, 4'd0, 64'd50, '0, 1'b0);
    endtask

    // Arms every timer and lets them all expire in one tick, the longest burst of reports.
    task automatic test_full_bank_expiry();
        for (int i = 0; i < NUM_TIMERS; i++)
            send_request(REQ_CONFIG, i[IDX_W-1:0], rand64(), 64'($urandom_range(400, 1)),
                         1'($urandom_range(1)));
        for (int i = 0; i < NUM_TIMERS; i++)
            send_request(REQ_START, i[IDX_W-1:0], sim_now, rand64(), 1'($urandom_range(1)));
        sim_now = sim_now + 64'd500;
        send_request(REQ_TICK, 4'($urandom), sim_now, rand64(), 1'($urandom_range(1)));
        sim_now = sim_now + 64'd500;
        send_request(REQ_TICK, 4'($urandom), sim_now, rand64(), 1'($urandom_range(1)));
    endtask

    // Mostly well-formed traffic on a slowly advancing clock, with some noise mixed in.
    task automatic test_random_traffic(int count);
        int                pick;
        logic [REQ_W-1:0]  req;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] period;
        logic              reload;
        for (int n = 0; n < count; n++)
        begin
            pick   = $urandom_range(99);
            idx    = 4'($urandom);
            now    = rand64();
            period = rand64();
            reload = 1'($urandom_range(1));
            if ($urandom_range(49) == 0)
                sim_now = rand64();
            if (pick < 14)
            begin
                req = REQ_CONFIG;
                if ($urandom_range(19) == 0)
                    period = '0;
                else if ($urandom_range(9) != 0)
                    period = 64'($urandom_range(400, 1));
            end
            else if (pick < 34)
            begin
                req = REQ_START;
                now = sim_now;
            end
            else if (pick < 42)
                req = REQ_STOP;
            else if (pick < 47)
                req = REQ_DELETE;
            else if (pick < 57)
            begin
                req = REQ_RESET;
                now = sim_now;
            end
            else if (pick < 90)
            begin
                req     = REQ_TICK;
                sim_now = sim_now + 64'($urandom_range(300));
                now     = sim_now;
            end
            else if (pick < 95)
                req = $urandom_range(1) ? REQ_BAD_6 : REQ_BAD_7;
            else
                req = 3'($urandom);
            send_request(req, idx, now, period, reload);
        end
    endtask

    // Result side: random back-pressure, changed on the falling edge.
    always @(negedge clk)
    begin
        if (snk_stall_en)
            m_axis_tready <= ($urandom_range(99) >= STALL_PCT);
        else
            m_axis_tready <= 1'b1;
    end

    // Compares every accepted result beat with the oldest queued expectation.
    always @(posedge clk)
    begin
        timer_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got data %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] !== want.status)
                begin
                    $display("%0t: status mismatch, expected %b, got %b",
                             $time, want.status, m_axis_tdata[0]);
                    err_count++;
                end
                if (m_axis_tdata[1] !== want.exp_valid)
                begin
                    $display("%0t: expired_valid mismatch, expected %b, got %b",
                             $time, want.exp_valid, m_axis_tdata[1]);
                    err_count++;
                end
                if (m_axis_tdata[5:2] !== want.exp_index)
                begin
                    $display("%0t: expired_index mismatch, expected %0d, got %0d",
                             $time, want.exp_index, m_axis_tdata[5:2]);
                    err_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: tlast mismatch, expected %b, got %b",
                             $time, want.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on progress: any accepted beat on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        src_stall_en  = 1'b1;
        snk_stall_en  = 1'b1;
        sim_now       = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            shadow_period[i] = '0;
            shadow_expiry[i] = '0;
            shadow_active[i] = 1'b0;
            shadow_reload[i] = 1'b0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_rejects();
        test_wrap_and_extremes();
        test_expiry_at_now();
        test_delete_restart();
        wait_for_drain();

        sim_now = 64'd1000;
        test_full_bank_expiry();
        wait_for_drain();

        // A stretch with both sides running flat out.
        src_stall_en = 1'b0;
        snk_stall_en = 1'b0;
        test_random_traffic(60);
        src_stall_en = 1'b1;
        snk_stall_en = 1'b1;
        wait_for_drain();

        test_random_traffic(100);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
